FILE: rtl/core/sc3_pkg.sv
// Shared constants, payload types and helpers for the 3x3 stencil filter.
package sc3_pkg;

   localparam int MAX_WIDTH    = 1024;
   localparam int MAX_HEIGHT   = 1024;
   localparam int ADDR_W       = $clog2(MAX_WIDTH);
   localparam int COUNT_W      = 10;
   localparam int SIZE_W       = 11;
   localparam int PIX_W        = 8;
   localparam int TAP_W        = 5;
   localparam int NUM_TAPS     = 9;
   localparam int TAPS_W       = TAP_W * NUM_TAPS;
   localparam int PROD_W       = TAP_W + PIX_W + 1;
   localparam int ROW_SUM_W    = PROD_W + 2;
   localparam int SUM_W        = 17;
   localparam int OFFSET_UNITS = 2250;
   localparam int CSR_ADDR_W   = 5;
   localparam int CSR_DATA_W   = 64;

   localparam logic [TAPS_W-1:0] KERNEL_TAPS_RESET = 45'd1066198336480;
   localparam logic [SIZE_W-1:0] IMAGE_SIZE_RESET  = 11'd100;

   typedef enum logic [1:0] {
      REG_KERNEL_TAPS  = 2'd0,
      REG_IMAGE_WIDTH  = 2'd1,
      REG_IMAGE_HEIGHT = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             frame_start;
   } req_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] scaled_value;
      logic [COUNT_W-1:0]      center_row;
      logic [COUNT_W-1:0]      center_col;
      logic                    frame_last;
   } rsp_type;

   typedef struct packed {
      logic [TAPS_W-1:0] kernel_taps;
      logic [SIZE_W-1:0] image_width;
      logic [SIZE_W-1:0] image_height;
   } cfg_type;

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                    input logic [SIZE_W-1:0] max_v);
      logic [SIZE_W-1:0] r;
      if (v < SIZE_W'(3)) begin
         r = SIZE_W'(3);
      end else if (v > max_v) begin
         r = max_v;
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic signed [TAP_W-1:0] tap_coef(input logic [TAPS_W-1:0] taps,
                                                        input int idx);
      return $signed(taps[TAP_W*idx +: TAP_W]);
   endfunction

endpackage

FILE: rtl/core/sc3_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module sc3_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read data holds until the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/sc3_csr.sv
// APB-style register file for kernel taps and frame size.
module sc3_csr
   import sc3_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (paddr[4:3])
            REG_KERNEL_TAPS:  cfg_in.kernel_taps  = pwdata[TAPS_W-1:0];
            REG_IMAGE_WIDTH:  cfg_in.image_width  = pwdata[SIZE_W-1:0];
            REG_IMAGE_HEIGHT: cfg_in.image_height = pwdata[SIZE_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kernel_taps  <= KERNEL_TAPS_RESET;
         cfg_ff.image_width  <= IMAGE_SIZE_RESET;
         cfg_ff.image_height <= IMAGE_SIZE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (paddr[4:3])
         REG_KERNEL_TAPS:  prdata = CSR_DATA_W'(cfg_ff.kernel_taps);
         REG_IMAGE_WIDTH:  prdata = CSR_DATA_W'(cfg_ff.image_width);
         REG_IMAGE_HEIGHT: prdata = CSR_DATA_W'(cfg_ff.image_height);
         default:          prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/core/stencil_conv_3x3.sv
// Streaming 3x3 weighted-sum filter with a RAM line buffer.
// An interior window's result passes line-buffer, product, row-sum and output registers.
// One pixel per cycle unless output stalls; line RAM read and written once per pixel.
// A same-column write still in flight when the next read issues is forwarded around the RAM.
// Reset clears counters, window, valids and forward flag, not stage data or the line RAM.
module stencil_conv_3x3
   import sc3_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   typedef struct packed {
      logic [PIX_W-1:0]   pixel;
      logic [COUNT_W-1:0] row;
      logic [COUNT_W-1:0] col;
      logic [ADDR_W-1:0]  addr;
      logic               emit;
      logic               last;
   } s1_type;

   typedef struct packed {
      logic [COUNT_W-1:0] center_row;
      logic [COUNT_W-1:0] center_col;
      logic               frame_last;
   } meta_type;

   cfg_type cfg;

   sc3_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // ---------------- accept stage: position and RAM read ----------------
   logic [COUNT_W-1:0] row_ff, col_ff, row_in, col_in;
   logic [COUNT_W-1:0] r0, c0;
   logic [SIZE_W-1:0]  w_eff, h_eff, c_next, r_next;
   logic [ADDR_W-1:0]  addr0;
   logic               emit0, last0, req_fire;

   logic               s1_v_ff, s1_fire, s2_open, s3_open, out_open;
   s1_type             s1_ff;

   assign w_eff = clamp_size(cfg.image_width, SIZE_W'(MAX_WIDTH));
   assign h_eff = clamp_size(cfg.image_height, SIZE_W'(MAX_HEIGHT));

   assign req_ready = !s1_v_ff || s1_fire;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      r0     = req_data.frame_start ? '0 : row_ff;
      c0     = req_data.frame_start ? '0 : col_ff;
      addr0  = ADDR_W'(c0);
      emit0  = (r0 >= COUNT_W'(2)) && (c0 >= COUNT_W'(2))
               && ({1'b0, r0} < h_eff) && ({1'b0, c0} < w_eff);
      last0  = ({1'b0, r0} == h_eff - SIZE_W'(1)) && ({1'b0, c0} == w_eff - SIZE_W'(1));
      c_next = {1'b0, c0} + SIZE_W'(1);
      r_next = {1'b0, r0} + SIZE_W'(1);
      if (c_next >= w_eff) begin
         col_in = '0;
         row_in = (r_next >= h_eff) ? '0 : r_next[COUNT_W-1:0];
      end else begin
         col_in = c_next[COUNT_W-1:0];
         row_in = r0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (req_fire) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // ---------------- line-buffer stage ----------------
   logic [2*PIX_W-1:0] ram_rdata, pair, wr_data, fwd_data_ff;
   logic               fwd_ff;
   logic [PIX_W-1:0]   top_px, mid_px;
   logic [PIX_W-1:0]   win_ff [NUM_TAPS];
   logic [PIX_W-1:0]   win_in [NUM_TAPS];
   logic signed [PROD_W-1:0] prod_in [NUM_TAPS];

   sc3_ram #(
      .WIDTH (2*PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_fire),
      .wr_addr (s1_ff.addr),
      .wr_data (wr_data),
      .rd_en   (req_fire),
      .rd_addr (addr0),
      .rd_data (ram_rdata)
   );

   // upper byte: two rows above, lower byte: one row above
   assign pair    = fwd_ff ? fwd_data_ff : ram_rdata;
   assign top_px  = pair[2*PIX_W-1:PIX_W];
   assign mid_px  = pair[PIX_W-1:0];
   assign wr_data = {mid_px, s1_ff.pixel};
   assign s1_fire = s1_v_ff && (!s1_ff.emit || s2_open);

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         win_in[k*3]     = win_ff[k*3+1];
         win_in[k*3 + 1] = win_ff[k*3+2];
      end
      win_in[2] = top_px;
      win_in[5] = mid_px;
      win_in[8] = s1_ff.pixel;
      for (int k = 0; k < NUM_TAPS; k++) begin
         prod_in[k] = PROD_W'(tap_coef(cfg.kernel_taps, k) * $signed({1'b0, win_in[k]}));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         fwd_ff  <= 1'b0;
      end else begin
         if (req_ready) begin
            s1_v_ff <= req_valid;
         end
         if (req_fire) begin
            // same column written this cycle: RAM returns stale data
            fwd_ff <= s1_fire && (s1_ff.addr == addr0);
         end else if (s1_fire) begin
            fwd_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_ff.pixel <= req_data.pixel;
         s1_ff.row   <= r0;
         s1_ff.col   <= c0;
         s1_ff.addr  <= addr0;
         s1_ff.emit  <= emit0;
         s1_ff.last  <= last0;
         fwd_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_TAPS; k++) begin
            win_ff[k] <= '0;
         end
      end else if (s1_fire) begin
         win_ff <= win_in;
      end
   end

   // ---------------- products, row sums, output ----------------
   logic                        s2_v_ff, s3_v_ff, out_v_ff;
   logic signed [PROD_W-1:0]    prod_ff [NUM_TAPS];
   logic signed [ROW_SUM_W-1:0] row_sum_ff [3];
   logic signed [ROW_SUM_W-1:0] row_sum_in [3];
   logic signed [SUM_W-1:0]     total_in;
   meta_type                    s2_meta_ff, s3_meta_ff;
   rsp_type                     rsp_ff;

   assign out_open = !out_v_ff || rsp_ready;
   assign s3_open  = !s3_v_ff || out_open;
   assign s2_open  = !s2_v_ff || s3_open;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         row_sum_in[k] = ROW_SUM_W'(prod_ff[k*3]) + ROW_SUM_W'(prod_ff[k*3+1])
                         + ROW_SUM_W'(prod_ff[k*3+2]);
      end
      total_in = SUM_W'(row_sum_ff[0]) + SUM_W'(row_sum_ff[1]) + SUM_W'(row_sum_ff[2])
                 + SUM_W'(OFFSET_UNITS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (s2_open) begin
            s2_v_ff <= s1_fire && s1_ff.emit;
         end
         if (s3_open) begin
            s3_v_ff <= s2_v_ff;
         end
         if (out_open) begin
            out_v_ff <= s3_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_open) begin
         prod_ff               <= prod_in;
         s2_meta_ff.center_row <= s1_ff.row - COUNT_W'(1);
         s2_meta_ff.center_col <= s1_ff.col - COUNT_W'(1);
         s2_meta_ff.frame_last <= s1_ff.last;
      end
      if (s3_open) begin
         row_sum_ff <= row_sum_in;
         s3_meta_ff <= s2_meta_ff;
      end
      if (out_open) begin
         rsp_ff.scaled_value <= total_in;
         rsp_ff.center_row   <= s3_meta_ff.center_row;
         rsp_ff.center_col   <= s3_meta_ff.center_col;
         rsp_ff.frame_last   <= s3_meta_ff.frame_last;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = rsp_ff;

   // ---------------- checks ----------------
   a_frame_start_origin: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_data.frame_start |=> s1_ff.row == '0 && s1_ff.col == '0)
      else $error("frame start did not restart position");

   a_fwd_needs_item: assert property (@(posedge clock) disable iff (reset)
      fwd_ff |-> s1_v_ff)
      else $error("forward flag set with empty line-buffer stage");

   a_center_interior: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.center_row != '0 && rsp_data.center_col != '0)
      else $error("result for a border centre");

   a_emit_stall_holds: assert property (@(posedge clock) disable iff (reset)
      s1_v_ff && s1_ff.emit && !s2_open |=> s1_v_ff && $stable(s1_ff.addr))
      else $error("stalled window pixel lost");

endmodule
